### design/lkvc_pkg.sv
package lkvc_pkg;

    // Request kinds on the input channel.
    localparam logic KIND_GET = 1'b0;
    localparam logic KIND_PUT = 1'b1;

    localparam int          DATA_WIDTH     = 32;
    localparam int          CAP_WIDTH      = 5;
    localparam logic [4:0]  CAPACITY_RESET = 5'd16;
    localparam logic [31:0] MISS_VALUE     = 32'hFFFF_FFFF;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_LOOK = 2'b10
    } t_state;

endpackage

### design/lru_key_value_cache.sv
// Fully associative key-value cache with least-recently-used replacement. A word on the
// input channel is either a get or a put. A request is first registered; then its key is
// compared against all tags in parallel and the tags, recency ranks and value memory are
// updated. The value memory read of a get completes at the end of the compare step, and
// the word moves into the output register once that register has room and is offered on
// the output channel; a put returns nothing. A new request is taken only after the last
// one's compare step and unless a get result is held back from the output register. The
// capacity register (1 to DEPTH, 0 acts as 1, larger values act as DEPTH) may only be
// written while the cache is idle. The cache is empty after reset.
module lru_key_value_cache
    import lkvc_pkg::*;
#(
    parameter int DEPTH       = 16,
    parameter int KEY_WIDTH   = 32,
    parameter int VALUE_WIDTH = 32
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_wr_en,
    input  logic [CAP_WIDTH-1:0]         i_cfg_wr_data,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  logic                         i_kind,
    input  logic signed [DATA_WIDTH-1:0] i_lookup_key,
    input  logic signed [DATA_WIDTH-1:0] i_store_value,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic                         o_hit,
    output logic signed [DATA_WIDTH-1:0] o_read_value
);

    localparam int IW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int RW   = IW;
    localparam int CW   = $clog2(DEPTH + 1);
    localparam int CMPW = (CW > CAP_WIDTH) ? CW : CAP_WIDTH;
    localparam int KXW  = (KEY_WIDTH > DATA_WIDTH) ? KEY_WIDTH : DATA_WIDTH;
    localparam int VXW  = (VALUE_WIDTH > DATA_WIDTH) ? VALUE_WIDTH : DATA_WIDTH;

    t_state                 r_state, n_state;
    logic [CAP_WIDTH-1:0]   r_cap;
    logic [CW-1:0]          r_occ, n_occ;
    logic [DEPTH-1:0]       r_valid;
    logic [KEY_WIDTH-1:0]   r_keys [DEPTH];
    logic [RW-1:0]          r_rank [DEPTH];
    logic [VALUE_WIDTH-1:0] mem_values [DEPTH];
    logic [VALUE_WIDTH-1:0] r_rdata;

    logic                   r_kind;
    logic [KEY_WIDTH-1:0]   r_key;
    logic [VALUE_WIDTH-1:0] r_value;

    logic                   r_res_pend;
    logic                   r_res_hit;
    logic                   r_out_valid;
    logic                   r_out_hit;
    logic [DATA_WIDTH-1:0]  r_out_value;

    logic                   w_accept;
    logic                   w_res_move;
    logic                   w_look;
    logic [KXW-1:0]         w_key_ext;
    logic [VXW-1:0]         w_val_ext;
    logic [VXW-1:0]         w_rd_ext;
    logic [DEPTH-1:0]       w_match;
    logic [DEPTH-1:0]       w_victim;
    logic [DEPTH-1:0]       w_free;
    logic                   w_hit;
    logic [IW-1:0]          w_hit_idx;
    logic [RW-1:0]          w_old_rank;
    logic [IW-1:0]          w_slot;
    logic [CMPW-1:0]        w_eff_cap;
    logic                   w_full;
    logic                   w_evict;
    logic                   w_insert;
    logic [CW-1:0]          w_occ_m1;
    logic [RW-1:0]          w_last_rank;
    logic                   w_mem_we;
    logic [IW-1:0]          w_mem_addr;

    assign w_res_move = r_res_pend && (!r_out_valid || i_out_ready);
    assign o_in_ready = (r_state == ST_IDLE) && (!r_res_pend || w_res_move);
    assign w_accept   = i_in_valid && o_in_ready;
    assign w_look     = (r_state == ST_LOOK);

    assign w_key_ext = KXW'($unsigned(i_lookup_key));
    assign w_val_ext = VXW'($unsigned(i_store_value));
    assign w_rd_ext  = VXW'(r_rdata);

    // Tag compare and per-entry reductions; keys are unique among valid entries.
    always_comb begin
        w_hit_idx  = '0;
        w_old_rank = '0;
        for (int j = 0; j < DEPTH; j++) begin
            w_match[j] = r_valid[j] && (r_keys[j] == r_key);
            if (w_match[j]) begin
                w_hit_idx = w_hit_idx | IW'(j);
            end
            w_old_rank = w_old_rank | (r_rank[j] & {RW{w_match[j]}});
        end
    end
    assign w_hit = |w_match;

    always_comb begin
        if (r_cap == '0) begin
            w_eff_cap = CMPW'(1);
        end else if (CMPW'(r_cap) > CMPW'(DEPTH)) begin
            w_eff_cap = CMPW'(DEPTH);
        end else begin
            w_eff_cap = CMPW'(r_cap);
        end
    end
    assign w_full      = CMPW'(r_occ) >= w_eff_cap;
    assign w_insert    = w_look && (r_kind == KIND_PUT) && !w_hit;
    assign w_evict     = w_insert && w_full;
    assign w_occ_m1    = r_occ - CW'(1);
    assign w_last_rank = w_occ_m1[RW-1:0];

    // Valid ranks are always a permutation of 0 .. occupancy-1, so the least recent
    // entry is the one holding the highest rank.
    always_comb begin
        w_slot = '0;
        for (int j = DEPTH - 1; j >= 0; j--) begin
            w_victim[j] = r_valid[j] && (r_rank[j] == w_last_rank);
            w_free[j]   = !r_valid[j] || (w_full && w_victim[j]);
            if (w_free[j]) begin
                w_slot = IW'(j);
            end
        end
    end

    assign n_occ = w_insert ? (w_full ? r_occ : r_occ + CW'(1)) : r_occ;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    n_state = ST_LOOK;
                end
            end
            ST_LOOK: begin
                n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cap   <= CAPACITY_RESET;
            r_occ   <= '0;
        end else begin
            r_state <= n_state;
            r_occ   <= n_occ;
            if (i_cfg_wr_en) begin
                r_cap <= i_cfg_wr_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_kind  <= i_kind;
            r_key   <= w_key_ext[KEY_WIDTH-1:0];
            r_value <= w_val_ext[VALUE_WIDTH-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (w_insert) begin
            for (int j = 0; j < DEPTH; j++) begin
                if (IW'(j) == w_slot) begin
                    r_valid[j] <= 1'b1;
                end else if (w_evict && w_victim[j]) begin
                    r_valid[j] <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_insert) begin
            for (int j = 0; j < DEPTH; j++) begin
                if (IW'(j) == w_slot) begin
                    r_keys[j] <= r_key;
                    r_rank[j] <= '0;
                end else if (r_valid[j] && !(w_evict && w_victim[j])) begin
                    r_rank[j] <= r_rank[j] + RW'(1);
                end
            end
        end else if (w_look && w_hit) begin
            for (int j = 0; j < DEPTH; j++) begin
                if (w_match[j]) begin
                    r_rank[j] <= '0;
                end else if (r_valid[j] && (r_rank[j] < w_old_rank)) begin
                    r_rank[j] <= r_rank[j] + RW'(1);
                end
            end
        end
    end

    assign w_mem_we   = w_look && (r_kind == KIND_PUT);
    assign w_mem_addr = w_hit ? w_hit_idx : w_slot;

    always_ff @(posedge i_clk) begin
        if (w_mem_we) begin
            mem_values[w_mem_addr] <= r_value;
        end
        if (w_look && (r_kind == KIND_GET)) begin
            r_rdata <= mem_values[w_hit_idx];
        end
    end

    // A get result waits here for the read data and then for room in the output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res_pend <= 1'b0;
        end else if (w_look && (r_kind == KIND_GET)) begin
            r_res_pend <= 1'b1;
        end else if (w_res_move) begin
            r_res_pend <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_look && (r_kind == KIND_GET)) begin
            r_res_hit <= w_hit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_res_move) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_res_move) begin
            r_out_hit   <= r_res_hit;
            r_out_value <= r_res_hit ? w_rd_ext[DATA_WIDTH-1:0] : MISS_VALUE;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_hit        = r_out_hit;
    assign o_read_value = r_out_value;

    a_single_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_look |-> $onehot0(w_match))
        else $error("key matches more than one valid entry");

    a_occ_tracks_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(r_valid) == int'(r_occ))
        else $error("occupancy count disagrees with valid marks");

    a_put_leaves_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_look && (r_kind == KIND_PUT)) |=> (r_occ != '0))
        else $error("cache empty after a put");

    a_pend_not_lost: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_res_pend && !w_res_move) |=> r_res_pend)
        else $error("pending get result dropped");

endmodule
